### rtl/mcdq_pkg.sv
`default_nettype none
package mcdq_pkg;

  // Fixed field widths of the stream words
  localparam int unsigned CLASS_W    = 5;
  localparam int unsigned EXT_ID_W   = 16;
  localparam int unsigned COUNT_W    = 4;
  localparam int unsigned CODE_W     = 2;
  localparam int unsigned IN_DATA_W  = 24;
  localparam int unsigned OUT_DATA_W = 24;

  // Operation carried in tuser
  localparam logic OP_ADD  = 1'b0;
  localparam logic OP_TAKE = 1'b1;

  typedef enum logic [CODE_W-1:0] {
    RES_DONE  = 2'd0,
    RES_FULL  = 2'd1,
    RES_EMPTY = 2'd2
  } result_e;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_LOOK = 4'b0010,
    ST_SLOT = 4'b0100,
    ST_DONE = 4'b1000
  } state_e;

  // Input word, lowest field last
  typedef struct packed {
    logic                is_urgent;
    logic [EXT_ID_W-1:0] entry_id;
    logic [CLASS_W-1:0]  class_index;
  } in_item_t;

  // Result word, lowest field last
  typedef struct packed {
    logic [COUNT_W-1:0]  class_count;
    logic                taken_urgent;
    logic [EXT_ID_W-1:0] taken_id;
    result_e             result_code;
  } out_item_t;

endpackage
`default_nettype wire

### rtl/mcdq_ctl_ram.sv
`default_nettype none
// Per-class state memory (head pointer and fill count).
// Valid bits make a never-written class read as all zero.
module mcdq_ctl_ram #(
  parameter int unsigned ENTRIES = 32,
  parameter int unsigned DATA_W  = 7
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       re_i,
  input  wire logic [$clog2(ENTRIES)-1:0] raddr_i,
  output logic      [DATA_W-1:0]          rdata_o,
  input  wire logic                       we_i,
  input  wire logic [$clog2(ENTRIES)-1:0] waddr_i,
  input  wire logic [DATA_W-1:0]          wdata_i
);

  logic [DATA_W-1:0]  mem [ENTRIES];
  logic [ENTRIES-1:0] vld_q;
  logic               rvld_q;
  logic [DATA_W-1:0]  rdata_q;

  // storage array and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  // valid bits, cleared at reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
    end else begin
      if (we_i) begin
        vld_q[waddr_i] <= 1'b1;
      end
      if (re_i) begin
        rvld_q <= vld_q[raddr_i];
      end
    end
  end

  assign rdata_o = rvld_q ? rdata_q : '0;

endmodule
`default_nettype wire

### rtl/mcdq_slot_ram.sv
`default_nettype none
// Single-port entry memory, registered read
module mcdq_slot_ram #(
  parameter int unsigned ENTRIES = 256,
  parameter int unsigned DATA_W  = 17
) (
  input  wire logic                       clk_i,
  input  wire logic                       en_i,
  input  wire logic                       we_i,
  input  wire logic [$clog2(ENTRIES)-1:0] addr_i,
  input  wire logic [DATA_W-1:0]          wdata_i,
  output logic      [DATA_W-1:0]          rdata_o
);

  logic [DATA_W-1:0] mem [ENTRIES];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem[addr_i] <= wdata_i;
      end else begin
        rdata_o <= mem[addr_i];
      end
    end
  end

endmodule
`default_nettype wire

### rtl/multi_class_deque_with_expedite.sv
// Flow: an accepted word's class state is read for ST_LOOK; a successful take adds
// an entry-memory read in ST_SLOT; ST_DONE then loads the result into the output
// register. A new word is accepted only in ST_IDLE, so one item is in flight, and
// the state-memory read-modify-write and output stalls hold off the next word.
// Reset: asynchronous, active low; class fill counts and heads read as zero via
// per-class valid bits cleared at reset. Entry memory is not cleared.
`default_nettype none
module multi_class_deque_with_expedite #(
  parameter int unsigned NUM_CLASSES = 32,
  parameter int unsigned DEPTH       = 8,
  parameter int unsigned ID_BITS     = 16
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  // fields low to high: class_index[4:0], entry_id[20:5], is_urgent[21], zero pad
  input  wire logic [mcdq_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  // fields: op[0]
  input  wire logic                             s_axis_tuser,
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  // fields low to high: result_code[1:0], taken_id[17:2], taken_urgent[18],
  // class_count[22:19], zero pad
  output logic      [mcdq_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready
);
  import mcdq_pkg::*;

  localparam int unsigned CLS_W  = $clog2(NUM_CLASSES);
  localparam int unsigned PTR_W  = $clog2(DEPTH);
  localparam int unsigned FILL_W = $clog2(DEPTH + 1);
  localparam int unsigned CTL_W  = PTR_W + FILL_W;
  localparam int unsigned SLOTS  = NUM_CLASSES * DEPTH;
  localparam int unsigned ADDR_W = $clog2(SLOTS);
  localparam int unsigned SLOT_W = ID_BITS + 1;

  state_e    state_q, state_d;
  in_item_t  in_item, item_q;
  logic      op_q;
  out_item_t res_q, res_d;
  logic      m_valid_q;
  logic [OUT_DATA_W-1:0] m_data_q;
  logic      accept;

  logic [CLS_W-1:0]  cls_idx;
  logic              cls_ok;
  logic [CTL_W-1:0]  ctl_rdata, ctl_wdata;
  logic              ctl_we;
  logic [FILL_W-1:0] fill, fill_inc, fill_dec;
  logic [PTR_W-1:0]  head, head_dec, head_inc, tail_pos, slot_pos;
  logic [PTR_W:0]    tail_sum;
  logic [ADDR_W-1:0] slot_addr;
  logic              slot_en, slot_we;
  logic [SLOT_W-1:0] slot_wdata, slot_rdata;

  assign in_item       = in_item_t'(s_axis_tdata[$bits(in_item_t)-1:0]);
  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;

  // per-class head/fill memory
  mcdq_ctl_ram #(
    .ENTRIES (NUM_CLASSES),
    .DATA_W  (CTL_W)
  ) u_ctl_ram (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .re_i    (accept),
    .raddr_i (CLS_W'(in_item.class_index)),
    .rdata_o (ctl_rdata),
    .we_i    (ctl_we),
    .waddr_i (cls_idx),
    .wdata_i (ctl_wdata)
  );

  // entry memory: {urgent, id}
  mcdq_slot_ram #(
    .ENTRIES (SLOTS),
    .DATA_W  (SLOT_W)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .en_i    (slot_en),
    .we_i    (slot_we),
    .addr_i  (slot_addr),
    .wdata_i (slot_wdata),
    .rdata_o (slot_rdata)
  );

  // pointer arithmetic on the fetched class state
  assign cls_idx  = CLS_W'(item_q.class_index);
  assign cls_ok   = (32'(item_q.class_index) < NUM_CLASSES);
  assign fill     = ctl_rdata[FILL_W-1:0];
  assign head     = ctl_rdata[CTL_W-1:FILL_W];
  assign fill_inc = FILL_W'(fill + 1'b1);
  assign fill_dec = FILL_W'(fill - 1'b1);
  assign head_dec = (head == '0) ? PTR_W'(DEPTH - 1) : PTR_W'(head - 1'b1);
  assign head_inc = (head == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(head + 1'b1);
  assign tail_sum = {1'b0, head} + (PTR_W + 1)'(fill);
  assign tail_pos = (tail_sum >= (PTR_W + 1)'(DEPTH)) ?
                    PTR_W'(tail_sum - (PTR_W + 1)'(DEPTH)) : PTR_W'(tail_sum);
  assign slot_addr = ADDR_W'(ADDR_W'(cls_idx) * ADDR_W'(DEPTH) + ADDR_W'(slot_pos));
  assign slot_wdata = {item_q.is_urgent, ID_BITS'(item_q.entry_id)};

  // sequencer: fetch class state, update, deliver
  always_comb begin
    state_d   = state_q;
    res_d     = res_q;
    ctl_we    = 1'b0;
    ctl_wdata = ctl_rdata;
    slot_en   = 1'b0;
    slot_we   = 1'b0;
    slot_pos  = head;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_LOOK;
        end
      end
      ST_LOOK: begin
        res_d.taken_id     = '0;
        res_d.taken_urgent = 1'b0;
        state_d            = ST_DONE;
        if (!cls_ok) begin
          res_d.result_code = (op_q == OP_TAKE) ? RES_EMPTY : RES_FULL;
          res_d.class_count = '0;
        end else if (op_q == OP_ADD) begin
          if (32'(fill) >= DEPTH) begin
            res_d.result_code = RES_FULL;
            res_d.class_count = COUNT_W'(fill);
          end else begin
            slot_en           = 1'b1;
            slot_we           = 1'b1;
            slot_pos          = item_q.is_urgent ? head_dec : tail_pos;
            ctl_we            = 1'b1;
            ctl_wdata         = {(item_q.is_urgent ? head_dec : head), fill_inc};
            res_d.result_code = RES_DONE;
            res_d.class_count = COUNT_W'(fill_inc);
          end
        end else begin
          if (fill == '0) begin
            res_d.result_code = RES_EMPTY;
            res_d.class_count = '0;
          end else begin
            slot_en           = 1'b1;
            ctl_we            = 1'b1;
            ctl_wdata         = {head_inc, fill_dec};
            res_d.result_code = RES_DONE;
            res_d.class_count = COUNT_W'(fill_dec);
            state_d           = ST_SLOT;
          end
        end
      end
      ST_SLOT: begin
        res_d.taken_id     = EXT_ID_W'(slot_rdata[ID_BITS-1:0]);
        res_d.taken_urgent = slot_rdata[ID_BITS];
        state_d            = ST_DONE;
      end
      ST_DONE: begin
        if (!m_valid_q || m_axis_tready) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_DONE && (!m_valid_q || m_axis_tready)) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= in_item;
      op_q   <= s_axis_tuser;
    end
    res_q <= res_d;
    if (state_q == ST_DONE && (!m_valid_q || m_axis_tready)) begin
      m_data_q <= OUT_DATA_W'(res_q);
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  // checks
  a_accept_fetch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == ST_LOOK)
    else $error("accepted word did not start a state fetch");

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_LOOK |-> 32'(fill) <= DEPTH)
    else $error("class fill count beyond depth");

  a_slot_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SLOT |-> $past(state_q) == ST_LOOK && op_q == OP_TAKE)
    else $error("entry read stage without a take");

  a_code_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[CODE_W-1:0] != 2'b11)
    else $error("undefined result code on output");

endmodule
`default_nettype wire
